/* rtl/core/rvra_pkg.sv */
// ----------------------------------------------------------------------------
// rvra_pkg
// Shared types and codes of the rover arena allocator.
// ----------------------------------------------------------------------------
package rvra_pkg;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_FRAME = 2'd2;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_EVICT = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_WIDTH = 3'd1;
	localparam logic [2:0] ERR_SIZE  = 3'd2;
	localparam logic [2:0] ERR_ARENA = 3'd3;
	localparam logic [2:0] ERR_END   = 3'd4;

	localparam logic [5:0] SLOT_NONE = 6'd63;
	localparam int unsigned ARENA_RESET = 262144;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_INIT,      // rebuild arena as one free block
		OP_LOAD,      // latch the input item, compute padded size
		OP_FRAME,     // record rover offset, clear wrap
		OP_WRAPCHK,   // decide wrap and select the rover block
		OP_EVICT_NB,  // clear owner of the rover block
		OP_STEP,      // look at next block of the chain
		OP_MERGE,     // merge next block into the rover block
		OP_SPLIT,     // split leftover / move rover, record new owner
		OP_DIV_STEP,  // one bit of the rows division
		OP_FLUSH_EVT, // clear owner of walk slot and advance
		OP_FLUSH_SEL  // select walk slot
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic        bad_width;
		logic        bad_size;
		logic        bad_arena;
		logic        fits;        // rover block already large enough
		logic        chain_end;   // next block missing or MAX_BLOCKS merges done
		logic        owner_nz;    // owner of the looked-at slot is nonzero
		logic        walk_live;   // flush walk slot live
		logic        div_done;
	} stat_t;

endpackage

/* rtl/core/rover_arena_allocator.sv */
// A flush walks the live blocks, then rebuilds the arena; an allocation
// merges blocks as needed and then runs the bit-serial rows division.
// One item is handled at a time; evictions wait on the output register, so a
// stalled consumer stretches the item. Reset (arst_n low) rebuilds the arena
// as one free block of 262144 bytes at once; a configuration write sets the
// arena size and rebuilds the arena as one free block in the same cycle.
// ----------------------------------------------------------------------------
// rover_arena_allocator
// Circular rover cache allocator: controller plus block table datapath.
// ----------------------------------------------------------------------------
module rover_arena_allocator import rvra_pkg::*; #(
	parameter int MAX_BLOCKS   = 32,
	parameter int HEADER_BYTES = 60,
	parameter int MIN_FRAGMENT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [22:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [8:0]  req_width,
	input  logic [16:0] req_bytes,
	input  logic [15:0] owner_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [21:0] block_offset,
	output logic [15:0] evicted_tag,
	output logic [16:0] rows,
	output logic        thrash,
	output logic [2:0]  error_code,
	output logic        last
);
	// The controller walks the block chain one block per item step, and the
	// datapath holds the slot tables, rover and frame state.
	cmd_t        cmd;
	stat_t       stat;
	logic [21:0] nb_offset;
	logic [15:0] look_owner;
	logic [16:0] rows_dp;
	logic        thr_dp;

	rvra_datapath #(
		.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES), .MIN_FRAGMENT(MIN_FRAGMENT)
	) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.cfg_we(cfg_valid && cfg_ready), .cfg_data,
		.req_width, .req_bytes, .owner_tag,
		.nb_offset, .look_owner, .rows_out(rows_dp), .thrash_out(thr_dp)
	);

	rvra_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .command, .cfg_valid, .cfg_ready,
		.cmd, .stat, .nb_offset, .look_owner, .rows_in(rows_dp), .thrash_in(thr_dp),
		.out_valid, .out_ready, .kind, .block_offset, .evicted_tag, .rows,
		.thrash, .error_code, .last
	);

endmodule

/* rtl/core/rvra_datapath.sv */
// ----------------------------------------------------------------------------
// rvra_datapath
// Block tables, rover state, padded size and bit-serial rows divider.
// ----------------------------------------------------------------------------
module rvra_datapath import rvra_pkg::*; #(
	parameter int MAX_BLOCKS   = 32,
	parameter int HEADER_BYTES = 60,
	parameter int MIN_FRAGMENT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_we,
	input  logic [22:0] cfg_data,
	input  logic [8:0]  req_width,
	input  logic [16:0] req_bytes,
	input  logic [15:0] owner_tag,
	output logic [21:0] nb_offset,
	output logic [15:0] look_owner,
	output logic [16:0] rows_out,
	output logic        thrash_out
);
	localparam int SW = $clog2(MAX_BLOCKS);

	logic [21:0] off_q   [MAX_BLOCKS];
	logic [22:0] size_q  [MAX_BLOCKS];
	logic [5:0]  next_q  [MAX_BLOCKS];
	logic [15:0] owner_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] used_q;

	logic [22:0] arena_q, froff_q, padded_q;
	logic [5:0]  rover_q, nb_q, look_q, walk_q;
	logic [5:0]  cnt_q;
	logic        wrap_q;
	logic [8:0]  width_q;
	logic [15:0] tag_q;
	logic [16:0] bytes_q;
	logic [16:0] quo_q, num_q;
	logic [8:0]  rem_q;
	logic [4:0]  dcnt_q;
	logic        wthis_q, thr_q;

	function automatic logic is_live(input logic [5:0] s, input logic [MAX_BLOCKS-1:0] u);
		logic r;
		r = 1'b0;
		if (s < 6'(MAX_BLOCKS)) r = u[s[SW-1:0]];
		return r;
	endfunction

	logic [22:0] cfg_v;
	always_comb begin
		cfg_v = {cfg_data[22:2], 2'b00};
		if (cfg_v < 23'd1024) cfg_v = 23'd1024;
		if (cfg_v > 23'd4194304) cfg_v = 23'd4194304;
	end

	// A configuration write rebuilds the arena at its new size right away.
	logic        do_init;
	logic [22:0] init_size;
	assign do_init   = cfg_we || cmd.op == OP_INIT;
	assign init_size = cfg_we ? cfg_v : arena_q;

	logic [SW-1:0] nbi, lki, wki;
	assign nbi = nb_q[SW-1:0];
	assign lki = look_q[SW-1:0];
	assign wki = walk_q[SW-1:0];

	logic [5:0]  nxt;
	logic        nxt_live;
	assign nxt      = next_q[nbi];
	assign nxt_live = is_live(nxt, used_q) && nxt != nb_q;

	// First free slot, used for the split.
	logic [5:0] free_s;
	always_comb begin
		free_s = SLOT_NONE;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--)
			if (!used_q[i]) free_s = 6'(i);
	end

	logic [22:0] left;
	assign left = size_q[nbi] - padded_q;

	logic [22:0] rov_off;
	assign rov_off = is_live(rover_q, used_q) ? {1'b0, off_q[rover_q[SW-1:0]]} : arena_q;

	logic [17:0] pad_c;
	assign pad_c = (18'(req_bytes) + 18'(HEADER_BYTES - 4 + 3)) & ~18'd3;

	logic [9:0] trial;
	assign trial = {rem_q, num_q[16]};

	assign stat.bad_width = width_q > 9'd256;
	assign stat.bad_size  = bytes_q == 17'd0 || bytes_q > 17'h10000;
	assign stat.bad_arena = padded_q > arena_q;
	assign stat.fits      = size_q[nbi] >= padded_q;
	assign stat.chain_end = !nxt_live || cnt_q >= 6'(MAX_BLOCKS);
	assign stat.owner_nz  = owner_q[lki] != 16'd0;
	assign stat.walk_live = is_live(walk_q, used_q) && cnt_q < 6'(MAX_BLOCKS);
	assign stat.div_done  = dcnt_q == 5'd0;

	assign nb_offset  = off_q[nbi];
	assign look_owner = owner_q[lki];
	assign rows_out   = (width_q == 9'd0) ? 17'd0 : quo_q;
	assign thrash_out = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				off_q[i] <= '0; next_q[i] <= SLOT_NONE; owner_q[i] <= '0;
				size_q[i] <= (i == 0) ? 23'(ARENA_RESET) : '0;
			end
			arena_q  <= 23'(ARENA_RESET);
			rover_q  <= '0;
			wrap_q   <= 1'b0;
			froff_q  <= '0;
			padded_q <= '0;
			nb_q     <= '0;
			look_q   <= '0;
			walk_q   <= '0;
			cnt_q    <= '0;
			width_q  <= '0;
			tag_q    <= '0;
			bytes_q  <= '0;
			quo_q    <= '0;
			num_q    <= '0;
			rem_q    <= '0;
			dcnt_q   <= '0;
			wthis_q  <= 1'b0;
			thr_q    <= 1'b0;
		end else begin
			if (cfg_we) arena_q <= cfg_v;
			if (do_init) begin
				used_q <= {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
				for (int i = 0; i < MAX_BLOCKS; i++) begin
					off_q[i] <= '0; next_q[i] <= SLOT_NONE; owner_q[i] <= '0;
					size_q[i] <= (i == 0) ? init_size : '0;
				end
				rover_q <= '0;
			end else begin
				case (cmd.op)
					OP_LOAD: begin
						width_q  <= req_width;
						bytes_q  <= req_bytes;
						tag_q    <= owner_tag;
						padded_q <= 23'(pad_c);
						walk_q   <= '0;
						cnt_q    <= '0;
					end
					OP_FRAME: begin
						froff_q <= rov_off;
						wrap_q  <= 1'b0;
					end
					OP_WRAPCHK: begin
						if (!is_live(rover_q, used_q) || {1'b0, off_q[rover_q[SW-1:0]]} >
								arena_q - padded_q) begin
							wthis_q <= is_live(rover_q, used_q);
							nb_q <= '0; look_q <= '0;
						end else begin
							wthis_q <= 1'b0;
							nb_q <= rover_q; look_q <= rover_q;
						end
						cnt_q <= '0;
					end
					OP_EVICT_NB: owner_q[lki] <= '0;
					OP_STEP: begin
						look_q <= nxt;
						if (stat.chain_end) rover_q <= nb_q;
					end
					OP_MERGE: begin
						owner_q[lki] <= '0;
						size_q[nbi] <= size_q[nbi] + size_q[lki];
						next_q[nbi] <= next_q[lki];
						used_q[lki] <= 1'b0;
						cnt_q <= cnt_q + 6'd1;
					end
					OP_SPLIT: begin
						logic [5:0] ro;
						if (left > 23'(MIN_FRAGMENT) && free_s != SLOT_NONE) begin
							off_q[free_s[SW-1:0]]   <= off_q[nbi] + padded_q[21:0];
							size_q[free_s[SW-1:0]]  <= left;
							next_q[free_s[SW-1:0]]  <= next_q[nbi];
							owner_q[free_s[SW-1:0]] <= '0;
							used_q[free_s[SW-1:0]]  <= 1'b1;
							next_q[nbi] <= free_s;
							size_q[nbi] <= padded_q;
							ro = free_s;
						end else begin
							ro = is_live(next_q[nbi], used_q) ? next_q[nbi] : SLOT_NONE;
						end
						rover_q <= ro;
						owner_q[nbi] <= tag_q;
						thr_q <= 1'b0;
						if (wrap_q) begin
							if (wthis_q || (ro == free_s && ro != SLOT_NONE &&
									left > 23'(MIN_FRAGMENT) ?
									{1'b0, off_q[nbi] + padded_q[21:0]} :
									(is_live(ro, used_q) ? {1'b0, off_q[ro[SW-1:0]]} : arena_q))
									>= froff_q)
								thr_q <= 1'b1;
						end else if (wthis_q) wrap_q <= 1'b1;
						num_q  <= padded_q[16:0] + 17'(4 - HEADER_BYTES);
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= 5'd17;
					end
					OP_DIV_STEP: begin
						if (trial >= {1'b0, width_q}) begin
							rem_q <= 9'(trial - {1'b0, width_q});
							quo_q <= {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= trial[8:0];
							quo_q <= {quo_q[15:0], 1'b0};
						end
						num_q  <= {num_q[15:0], 1'b0};
						dcnt_q <= dcnt_q - 5'd1;
					end
					OP_FLUSH_SEL: begin
						look_q <= walk_q;
					end
					OP_FLUSH_EVT: begin
						owner_q[wki] <= '0;
						walk_q <= next_q[wki];
						cnt_q  <= cnt_q + 6'd1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

/* rtl/core/rvra_ctrl.sv */
// ----------------------------------------------------------------------------
// rvra_ctrl
// Controller sequencing allocate, flush and frame commands.
// ----------------------------------------------------------------------------
module rvra_ctrl import rvra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	output cmd_t        cmd,
	input  stat_t       stat,
	input  logic [21:0] nb_offset,
	input  logic [15:0] look_owner,
	input  logic [16:0] rows_in,
	input  logic        thrash_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [21:0] block_offset,
	output logic [15:0] evicted_tag,
	output logic [16:0] rows,
	output logic        thrash,
	output logic [2:0]  error_code,
	output logic        last
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_WRAP, S_EV_NB, S_FIT, S_MERGE, S_SPLIT, S_DIV, S_DONE,
		S_FL_SEL, S_FL_EV, S_OUT, S_INIT
	} state_t;

	state_t st_q;

	// A pending configuration write takes precedence over a new item.
	assign cfg_ready = st_q == S_IDLE && !out_valid;
	assign in_ready  = st_q == S_IDLE && !out_valid && !cfg_valid;

	always_comb begin
		cmd.op = OP_NOP;
		case (st_q)
			S_IDLE:   if (in_valid && in_ready) cmd.op = (command == CMD_FRAME) ? OP_FRAME
					: OP_LOAD;
			S_WRAP:   cmd.op = OP_WRAPCHK;
			S_EV_NB:  if (!out_valid) cmd.op = OP_EVICT_NB;
			S_FIT:    if (!stat.fits) cmd.op = OP_STEP;
			S_MERGE:  if (!out_valid) cmd.op = OP_MERGE;
			S_SPLIT:  cmd.op = OP_SPLIT;
			S_DIV:    if (!stat.div_done) cmd.op = OP_DIV_STEP;
			S_FL_SEL: cmd.op = OP_FLUSH_SEL;
			S_FL_EV:  if (!out_valid) cmd.op = OP_FLUSH_EVT;
			S_INIT:   cmd.op = OP_INIT;
			default:  cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0;
			kind <= '0; block_offset <= '0; evicted_tag <= '0; rows <= '0;
			thrash <= 1'b0; error_code <= '0; last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && in_ready) begin
					case (command)
						CMD_ALLOC: st_q <= S_CHECK;
						CMD_FLUSH: st_q <= S_FL_SEL;
						CMD_FRAME: begin
							out_valid <= 1'b1; kind <= KIND_DONE; block_offset <= '0;
							evicted_tag <= '0; rows <= '0; thrash <= 1'b0;
							error_code <= ERR_NONE; last <= 1'b1;
						end
						default: ;
					endcase
				end
				S_CHECK: begin
					if (stat.bad_width || stat.bad_size || stat.bad_arena) begin
						out_valid <= 1'b1; kind <= KIND_ERROR; block_offset <= '0;
						evicted_tag <= '0; rows <= '0; thrash <= 1'b0; last <= 1'b1;
						error_code <= stat.bad_width ? ERR_WIDTH :
							stat.bad_size ? ERR_SIZE : ERR_ARENA;
						st_q <= S_IDLE;
					end else st_q <= S_WRAP;
				end
				S_WRAP: st_q <= S_EV_NB;
				S_EV_NB: if (!out_valid) begin
					if (stat.owner_nz) begin
						out_valid <= 1'b1; kind <= KIND_EVICT; evicted_tag <= look_owner;
						block_offset <= '0; rows <= '0; thrash <= 1'b0;
						error_code <= ERR_NONE; last <= 1'b0;
					end
					st_q <= S_FIT;
				end
				S_FIT: begin
					if (stat.fits) st_q <= S_SPLIT;
					else if (stat.chain_end) st_q <= S_DONE;
					else st_q <= S_MERGE;
				end
				S_MERGE: if (!out_valid) begin
					if (stat.owner_nz) begin
						out_valid <= 1'b1; kind <= KIND_EVICT; evicted_tag <= look_owner;
						block_offset <= '0; rows <= '0; thrash <= 1'b0;
						error_code <= ERR_NONE; last <= 1'b0;
					end
					st_q <= S_FIT;
				end
				S_SPLIT: st_q <= S_DIV;
				S_DIV: if (stat.div_done && !out_valid) begin
					out_valid <= 1'b1; kind <= KIND_ALLOC; block_offset <= nb_offset;
					evicted_tag <= '0; rows <= rows_in; thrash <= thrash_in;
					error_code <= ERR_NONE; last <= 1'b1;
					st_q <= S_IDLE;
				end
				S_DONE: if (!out_valid) begin
					out_valid <= 1'b1; kind <= KIND_ERROR; block_offset <= '0;
					evicted_tag <= '0; rows <= '0; thrash <= 1'b0;
					error_code <= ERR_END; last <= 1'b1;
					st_q <= S_IDLE;
				end
				S_FL_SEL: st_q <= stat.walk_live ? S_FL_EV : S_INIT;
				S_FL_EV: if (!out_valid) begin
					if (stat.owner_nz) begin
						out_valid <= 1'b1; kind <= KIND_EVICT; evicted_tag <= look_owner;
						block_offset <= '0; rows <= '0; thrash <= 1'b0;
						error_code <= ERR_NONE; last <= 1'b0;
					end
					st_q <= S_FL_SEL;
				end
				S_INIT: if (!out_valid) begin
					out_valid <= 1'b1; kind <= KIND_DONE; block_offset <= '0;
					evicted_tag <= '0; rows <= '0; thrash <= 1'b0;
					error_code <= ERR_NONE; last <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/rvra_checker.sv */
// ----------------------------------------------------------------------------
// rvra_checker
// Port-level checks of the rover arena allocator.
// ----------------------------------------------------------------------------
module rvra_checker import rvra_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [2:0] error_code,
	input logic       last
);
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last) else $error("error not last");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
		else $error("error without code");
	a_evict_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EVICT |-> !last) else $error("evict marked last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready) else $error("ready mid item");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind)) else $error("output dropped");
endmodule

bind rover_arena_allocator rvra_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .kind, .error_code, .last
);
